### rtl/sm3_pkg.sv
// SM3 package: constants, initial vector and round helper functions.
// No dependencies.
package sm3_pkg;
    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [31:0] IV [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

    typedef struct packed {
        logic [7:0] message_byte;
        logic       byte_present;
        logic       message_end;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } t_out_item;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction
endpackage

### rtl/sm3_if.sv
// SM3 stream channels: valid/ready with item payload.
// Depends on sm3_pkg.
interface sm3_in_if import sm3_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sm3_out_if import sm3_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/sm3_hash_engine.sv
// SM3 hash engine top level: byte gathering, padding, compression, digest.
// Depends on sm3_pkg and sm3_if.
// A byte item is accepted, then merged by a read-modify-write of the block
// word held in a registered-read memory; no item is taken until that is done.
// The byte that fills a block starts a compression: the load of the window and
// chaining value, 64 rounds and the feed-forward, during which no item is taken.
// A message end adds padding writes from the word of the end marker to word 15
// and two length writes, or zero writes to all 16 words and a second compression
// when the length no longer fits. The eight digest items then leave the output
// register one at a time, through the emit and wait states; the receiver can stall them.
module sm3_hash_engine
    import sm3_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    sm3_in_if.sink        i_in,
    sm3_out_if.source     o_out
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_BYTE  = 10'b0000000010,
        S_PAD   = 10'b0000000100,
        S_LEN   = 10'b0000001000,
        S_LOAD  = 10'b0000010000,
        S_ROUND = 10'b0000100000,
        S_CVRD  = 10'b0001000000,
        S_CVWR  = 10'b0010000000,
        S_EMIT  = 10'b0100000000,
        S_WAIT  = 10'b1000000000
    } t_state;

    logic [31:0] r_blk [16];
    logic [31:0] r_cv [8];
    logic [31:0] r_blk_q, r_cv_q;
    logic [3:0]  blk_ra, blk_wa;
    logic [31:0] blk_wd;
    logic        blk_we;
    logic [2:0]  cv_ra, cv_wa;
    logic [31:0] cv_wd;
    logic        cv_we;

    t_state      r_st, n_st;
    logic [63:0] r_cnt, n_cnt;
    logic [7:0]  r_byte, n_byte;
    logic        r_end, n_end;
    logic [3:0]  r_idx, n_idx;
    logic [6:0]  r_rnd, n_rnd;
    logic        r_final, n_final;
    logic        r_second, n_second;
    logic [7:0]  r_cvinit, n_cvinit;
    logic [31:0] r_reg [8];
    logic [31:0] n_reg [8];
    logic [31:0] r_win [16];
    logic [31:0] n_win [16];
    logic        r_ov, n_ov;
    t_out_item   r_od, n_od;
    logic [5:0]  pos;
    logic [31:0] cv_rd;

    always_ff @(posedge i_clk) begin
        if (blk_we) r_blk[blk_wa] <= blk_wd;
        r_blk_q <= (blk_we && blk_wa == blk_ra) ? blk_wd : r_blk[blk_ra];
        if (cv_we) r_cv[cv_wa] <= cv_wd;
        r_cv_q <= r_cvinit[cv_ra] ? IV[cv_ra] : r_cv[cv_ra];
    end

    assign pos   = r_cnt[8:3];
    assign cv_rd = r_cv_q;

    function automatic logic [31:0] put(input logic [31:0] w, input logic [1:0] b,
                                        input logic [7:0] v);
        logic [31:0] m;
        m = w;
        unique case (b)
            2'd0: m[31:24] = v;
            2'd1: m[23:16] = v;
            2'd2: m[15:8]  = v;
            default: m[7:0] = v;
        endcase
        return m;
    endfunction

    always_comb begin
        logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj, nw;
        n_st = r_st; n_cnt = r_cnt; n_byte = r_byte; n_end = r_end;
        n_idx = r_idx; n_rnd = r_rnd; n_final = r_final; n_second = r_second;
        n_cvinit = r_cvinit; n_reg = r_reg; n_win = r_win; n_ov = r_ov; n_od = r_od;
        blk_ra = pos[5:2]; blk_wa = pos[5:2]; blk_wd = '0; blk_we = 1'b0;
        cv_ra = r_idx[2:0]; cv_wa = r_idx[2:0]; cv_wd = '0; cv_we = 1'b0;
        i_in.ready = 1'b0;
        tj = (r_rnd < 7'd16) ? T_LOW : T_HIGH;
        a12 = rotl(r_reg[0], 5'd12);
        ss1 = rotl(a12 + r_reg[4] + rotl(tj, r_rnd[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (r_rnd < 7'd16) begin
            ff = r_reg[0] ^ r_reg[1] ^ r_reg[2];
            gg = r_reg[4] ^ r_reg[5] ^ r_reg[6];
        end else begin
            ff = (r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2]) | (r_reg[1] & r_reg[2]);
            gg = (r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]);
        end
        tt1 = ff + r_reg[3] + ss2 + (r_win[0] ^ r_win[4]);
        tt2 = gg + r_reg[7] + ss1 + r_win[0];
        nw = perm1(r_win[0] ^ r_win[7] ^ rotl(r_win[13], 5'd15))
             ^ rotl(r_win[3], 5'd7) ^ r_win[10];
        if (r_ov && o_out.ready) n_ov = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_byte = i_in.data.message_byte;
                    n_end  = i_in.data.message_end;
                    if (i_in.data.byte_present) n_st = S_BYTE;
                    else if (i_in.data.message_end) begin
                        n_st = S_PAD; n_idx = pos[5:2];
                    end
                end
            end
            S_BYTE: begin
                blk_we = 1'b1;
                blk_wd = put(r_blk_q, pos[1:0], r_byte);
                n_cnt = r_cnt + 64'd8;
                n_final = 1'b0;
                if (pos == 6'd63) begin
                    n_st = S_LOAD; n_idx = '0;
                end else if (r_end) begin
                    n_st = S_PAD; n_idx = n_cnt[8:5];
                end else n_st = S_IDLE;
            end
            S_PAD: begin
                // pad from word idx; r_blk_q holds word at pos when idx matches
                blk_wa = r_idx; blk_we = 1'b1;
                if (r_idx == pos[5:2])
                    blk_wd = put(r_blk_q & ~(32'hffffffff >> {pos[1:0], 3'b000}),
                                 pos[1:0], PAD_BYTE);
                else blk_wd = '0;
                if (r_second) blk_wd = '0;
                if (r_idx == 4'd15) begin
                    if (!r_second && pos >= 6'd56) begin
                        n_final = 1'b0; n_st = S_LOAD; n_idx = '0;
                    end else begin
                        n_st = S_LEN; n_idx = 4'd14;
                    end
                end else n_idx = r_idx + 4'd1;
            end
            S_LEN: begin
                blk_wa = r_idx; blk_we = 1'b1;
                blk_wd = (r_idx == 4'd14) ? r_cnt[63:32] : r_cnt[31:0];
                if (r_idx == 4'd15) begin
                    n_final = 1'b1; n_st = S_LOAD; n_idx = '0;
                end else n_idx = 4'd15;
            end
            S_LOAD: begin
                // read pipeline: address idx now, data next cycle
                blk_ra = r_idx; cv_ra = r_idx[2:0];
                if (r_rnd != 7'd0) begin
                    n_win[15] = r_blk_q;
                    for (int k = 0; k < 15; k++) n_win[k] = r_win[k+1];
                    if (r_rnd <= 7'd8) begin
                        n_reg[7] = cv_rd;
                        for (int k = 0; k < 7; k++) n_reg[k] = r_reg[k+1];
                    end
                end
                n_idx = r_idx + 4'd1;
                n_rnd = r_rnd + 7'd1;
                if (r_rnd == 7'd16) begin
                    n_rnd = '0; n_st = S_ROUND;
                end
            end
            S_ROUND: begin
                n_reg[3] = r_reg[2]; n_reg[2] = rotl(r_reg[1], 5'd9);
                n_reg[1] = r_reg[0]; n_reg[0] = tt1;
                n_reg[7] = r_reg[6]; n_reg[6] = rotl(r_reg[5], 5'd19);
                n_reg[5] = r_reg[4]; n_reg[4] = perm0(tt2);
                for (int k = 0; k < 15; k++) n_win[k] = r_win[k+1];
                n_win[15] = nw;
                n_rnd = r_rnd + 7'd1;
                if (r_rnd == 7'd63) begin
                    n_rnd = '0; n_idx = '0; n_st = S_CVRD;
                end
            end
            S_CVRD: n_st = S_CVWR;
            S_CVWR: begin
                cv_we = 1'b1;
                cv_wd = cv_rd ^ r_reg[r_idx[2:0]];
                n_cvinit[r_idx[2:0]] = 1'b0;
                n_idx = r_idx + 4'd1;
                if (r_idx == 4'd7) begin
                    n_idx = '0;
                    if (r_final) begin
                        n_st = S_EMIT;
                    end else if (r_end && !r_second) begin
                        n_second = 1'b1; n_st = S_PAD; n_idx = '0;
                    end else if (r_end) begin
                        n_st = S_LEN; n_idx = 4'd14;
                    end else n_st = S_IDLE;
                end else n_st = S_CVRD;
            end
            S_EMIT: begin
                if (!r_ov || o_out.ready) begin
                    n_st = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov = 1'b1;
                    n_od.digest_word = cv_rd;
                    n_od.digest_last = (r_idx == 4'd7);
                    n_idx = r_idx + 4'd1;
                    if (r_idx == 4'd7) begin
                        n_st = S_IDLE; n_idx = '0; n_cvinit = '1; n_cnt = '0;
                        n_end = 1'b0; n_second = 1'b0; n_final = 1'b0;
                    end else n_st = S_EMIT;
                end
            end
            default: n_st = S_IDLE;
        endcase
        if (r_st == S_CVWR && r_idx == 4'd7 && !r_final && r_end && !r_second
            && pos < 6'd56) begin
            n_st = S_PAD; n_idx = pos[5:2]; n_second = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_end <= 1'b0; r_idx <= '0; r_rnd <= '0;
            r_final <= 1'b0; r_second <= 1'b0; r_cvinit <= '1; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_end <= n_end; r_idx <= n_idx;
            r_rnd <= n_rnd; r_final <= n_final; r_second <= n_second;
            r_cvinit <= n_cvinit; r_ov <= n_ov;
        end
        r_byte <= n_byte; r_od <= n_od; r_reg <= n_reg; r_win <= n_win;
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;
endmodule

### rtl/sm3_checker.sv
// Port-level checker for the SM3 engine, bound to the top level.
// Depends on sm3_pkg and sm3_if.
module sm3_checker
    import sm3_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input t_out_item out_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output item dropped");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_data.digest_last |-> !in_ready)
        else $error("input taken during digest");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready && out_data.digest_last |=> in_ready || !out_valid)
        else $error("output after last word");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("output valid after reset");
endmodule

bind sm3_hash_engine sm3_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready), .out_data(o_out.data));

### sim/sm3_tb_if.sv
`timescale 1ns / 1ps
// Testbench constants shared by the digest checker.
// No dependencies.
package sm3_tb_pkg;
    localparam int DIGEST_WORDS = 8;
endpackage

### sim/sm3_digest_checker.sv
`timescale 1ns / 1ps
// Digest checker: watches the byte and digest channels, predicts SM3 digests, compares words and last flags.
// Depends on sm3_pkg and sm3_tb_pkg.
module sm3_digest_checker
    import sm3_pkg::*;
    import sm3_tb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_in_ready,
    input  t_in_item i_in_data,
    input  logic   i_out_valid,
    input  logic   i_out_ready,
    input  t_out_item i_out_data,
    output int     o_errors,
    output int     o_pending
);
    logic [31:0] chain [8];
    logic [31:0] blk [16];
    logic [63:0] nbits;
    t_out_item   digest_q [$];
    int          err_count = 0;

    function automatic logic [31:0] rl(input logic [31:0] x, input int n);
        n = n % 32;
        return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rl(x, 9) ^ rl(x, 17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rl(x, 15) ^ rl(x, 23);
    endfunction

    task automatic compress_block();
        logic [31:0] w [68];
        logic [31:0] r [8];
        logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2;
        for (int j = 0; j < 16; j++) w[j] = blk[j];
        for (int j = 16; j < 68; j++)
            w[j] = p1(w[j-16] ^ w[j-9] ^ rl(w[j-3], 15)) ^ rl(w[j-13], 7) ^ w[j-6];
        for (int j = 0; j < 8; j++) r[j] = chain[j];
        for (int j = 0; j < 64; j++) begin
            a12 = rl(r[0], 12);
            ss1 = rl(a12 + r[4] + rl((j < 16) ? T_LOW : T_HIGH, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                ff = r[0] ^ r[1] ^ r[2];
                gg = r[4] ^ r[5] ^ r[6];
            end else begin
                ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
                gg = (r[4] & r[5]) | (~r[4] & r[6]);
            end
            tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + r[7] + ss1 + w[j];
            r[3] = r[2]; r[2] = rl(r[1], 9); r[1] = r[0]; r[0] = tt1;
            r[7] = r[6]; r[6] = rl(r[5], 19); r[5] = r[4]; r[4] = p0(tt2);
        end
        for (int j = 0; j < 8; j++) chain[j] = chain[j] ^ r[j];
    endtask

    task automatic put_byte(input int pos, input logic [7:0] b);
        int sh;
        sh = 24 - 8 * (pos % 4);
        blk[pos / 4] = (blk[pos / 4] & ~(32'hff << sh)) | (32'(b) << sh);
    endtask

    task automatic take_item(input t_in_item it);
        int pos;
        t_out_item d;
        if (it.byte_present) begin
            pos = int'(nbits[8:3]);
            put_byte(pos, it.message_byte);
            nbits = nbits + 64'd8;
            if (pos == 63) compress_block();
        end
        if (it.message_end) begin
            pos = int'(nbits[8:3]);
            put_byte(pos, PAD_BYTE);
            for (int k = pos + 1; k < 64; k++) put_byte(k, 8'h00);
            if (pos >= 56) begin
                compress_block();
                for (int k = 0; k < 16; k++) blk[k] = '0;
            end
            blk[14] = nbits[63:32];
            blk[15] = nbits[31:0];
            compress_block();
            for (int k = 0; k < DIGEST_WORDS; k++) begin
                d.digest_word = chain[k];
                d.digest_last = (k == DIGEST_WORDS - 1);
                digest_q = {digest_q, d};
            end
            for (int k = 0; k < 8; k++) chain[k] = IV[k];
            nbits = '0;
        end
    endtask

    assign o_pending = digest_q.size();
    assign o_errors  = err_count;

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) chain[k] = IV[k];
            for (int k = 0; k < 16; k++) blk[k] = '0;
            nbits = '0;
            digest_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) take_item(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (digest_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected digest item %h last %b",
                                 i_out_data.digest_word, i_out_data.digest_last);
                end else begin
                    e = digest_q.pop_front();
                    if (e !== i_out_data) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("digest mismatch: expected %h/%b got %h/%b",
                                     e.digest_word, e.digest_last,
                                     i_out_data.digest_word, i_out_data.digest_last);
                    end
                end
            end
        end
    end
endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Testbench top: drives byte items into sm3_hash_engine, stalls the digest side, gives verdict.
// Depends on sm3_pkg, sm3_if and sm3_digest_checker.
module testbench;
    import sm3_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    logic hold_go = 1'b0;
    logic hold_active = 1'b0;
    logic stall_mode = 1'b0;
    int   in_count = 0;

    sm3_in_if  in_ch ();
    sm3_out_if out_ch ();

    sm3_hash_engine uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    sm3_digest_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_ready  (in_ch.ready),
        .i_in_data   (in_ch.data),
        .i_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_out_data  (out_ch.data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always #2 i_clk = ~i_clk;

    // long hold-off, counted here once requested
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    // receiver: long hold-off when active, else random stalls in stall mode, else always ready
    always @(posedge i_clk) begin
        if (hold_active) begin
            out_ch.ready <= 1'b0;
        end else if (stall_mode) begin
            out_ch.ready <= ($urandom_range(0, 3) != 0);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic send(input logic [7:0] b, input logic p, input logic e);
        t_in_item it;
        it.message_byte = b;
        it.byte_present = p;
        it.message_end  = e;
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        in_count++;
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= t_in_item'(10'($urandom));
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic message(input int len, input bit burst_gaps, input bit last_with_byte);
        int left;
        left = 0;
        for (int k = 0; k < len; k++) begin
            if (burst_gaps && left == 0) begin
                idle_gap($urandom_range(0, 4));
                left = $urandom_range(1, 20);
            end
            left--;
            if ($urandom_range(0, 15) == 0) send(8'($urandom), 1'b0, 1'b0);
            send(8'($urandom), 1'b1, (k == len - 1) && last_with_byte);
        end
        if (!last_with_byte || len == 0) send(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int len;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty, "abc", pad boundaries
        send(8'h00, 1'b0, 1'b0);
        send(8'hff, 1'b0, 1'b1);
        send(8'h61, 1'b1, 1'b0);
        send(8'h62, 1'b1, 1'b0);
        send(8'h63, 1'b1, 1'b1);
        send(8'h00, 1'b1, 1'b1);
        send(8'hff, 1'b1, 1'b1);
        message(55, 1'b0, 1'b1);
        message(56, 1'b0, 1'b0);
        // long hold-off while bytes keep coming
        hold_go <= 1'b1;
        message(3, 1'b0, 1'b1);
        message(3, 1'b0, 1'b1);
        message(2, 1'b0, 1'b1);
        stall_mode <= 1'b1;
        message(64, 1'b1, 1'b1);
        message(63, 1'b1, 1'b0);
        while (in_count < 410) begin
            case ($urandom_range(0, 3))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(50, 70);
                default: len = $urandom_range(0, 130);
            endcase
            message(len, 1'b1, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 5) == 0) stall_mode <= ~stall_mode;
        end
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
